>>> hdl/pixel_pca_distance_normalizer_unit_defines.svh
// Assertion macros shared by the pixel distance normalizer RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef PIXEL_PCA_DISTANCE_NORMALIZER_UNIT_DEFINES_SVH
`define PIXEL_PCA_DISTANCE_NORMALIZER_UNIT_DEFINES_SVH

// Plain clocked property with asynchronous active-low reset disable.
`define PPDN_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication to the following cycle.
`define PPDN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/ppdn_pkg.sv
// Package for the pixel distance normalizer: transfer structs, register indexes,
// reset values and fixed-point constants. Depends on nothing.
`default_nettype none

package ppdn_pkg;

	localparam int FRAME_PIXELS_DEF = 4096;
	localparam int CFG_W            = 64;
	localparam int CFG_IDX_W        = 3;

	localparam logic [CFG_IDX_W-1:0] REG_DIM0_A  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DIM0_B  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DIM1_A  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DIM1_B  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DIMS    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_THRESH  = 3'd5;

	localparam logic [1:0] DIMS_RST   = 2'd1;
	localparam logic [7:0] THRESH_RST = 8'd45;

	// Hue in Q9.7 degrees: 60 degrees is 7680, doubled for half-up rounding.
	localparam logic [15:0] HUE_STEP2  = 16'd15360;
	localparam logic [15:0] HUE_BASE_G = 16'd15360;
	localparam logic [15:0] HUE_BASE_B = 16'd30720;
	localparam logic [16:0] HUE_WRAP   = 17'd46080;

	// Level scale: twice the full 8-bit range, for half-up rounding.
	localparam logic [8:0] LEVEL_SCALE2 = 9'd510;
	localparam logic [7:0] LEVEL_MAX    = 8'd255;

	typedef struct packed {
		logic       op;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
		logic       last_pixel;
	} cmd_t;

	typedef struct packed {
		logic [7:0] level;
		logic       end_of_frame;
	} result_t;

	localparam logic OP_STORE = 1'b0;
	localparam logic OP_READ  = 1'b1;

	// Left shift applied to a product before it joins the projection sum.
	typedef enum logic [1:0] {
		SH_0,
		SH_8,
		SH_15
	} prod_shift_t;

endpackage

`default_nettype wire

>>> hdl/pixel_pca_distance_normalizer_unit.sv
// Top level of the pixel distance normalizer: HSV features, projection distance,
// frame store and min-max rescale. Depends on ppdn_pkg and the defines header.
`default_nettype none
`include "pixel_pca_distance_normalizer_unit_defines.svh"

// Usage. A command transfer happens at a clock edge with start high and busy low.
// A store command (op 0) brings one pixel; its distance and brightness flag go to
// the frame memory at the next free slot, and the frame min and max are updated.
// A store runs two 16-step shift-subtract divisions (saturation, then hue), a
// shared multiplier that walks the six feature terms of each dimension, and
// one weight multiply per dimension. Stores beyond the frame size are dropped
// at once (no busy), but their last_pixel mark still closes the frame.
// Once a frame is closed, further stores are ignored until it has been read.
// A read command (op 1) returns the next pixel: the frame memory is read, then a
// 16-step division runs and done is raised at its end. A read before the
// frame is closed gives nothing; a read of an empty closed frame answers in the
// next cycle with level 0 and end_of_frame set. The result is on the result
// port for exactly one cycle with done high; there is no back-pressure, and a
// new command may be given in that very cycle. The read of the final pixel
// clears the counts, min and max for the next frame. Reset clears the frame
// state and loads the register reset values; the frame memory needs no clearing
// because only slots written in the current frame are ever read.
module pixel_pca_distance_normalizer_unit #(
	parameter int FRAME_PIXELS = ppdn_pkg::FRAME_PIXELS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	output logic                                  busy,
	input  wire ppdn_pkg::cmd_t                   cmd,
	output logic                                  done,
	output ppdn_pkg::result_t                     result,
	input  wire logic                             cfg_we,
	input  wire logic [ppdn_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [ppdn_pkg::CFG_W-1:0]       cfg_data
);

	localparam int AW     = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;
	localparam int CW     = $clog2(FRAME_PIXELS + 1);
	localparam int DIV_W  = 48;
	localparam int ACC_W  = 48;
	localparam int MAG_W  = 43;
	localparam int SUM_W  = 60;

	typedef enum logic [8:0] {
		ST_IDLE    = 9'b000000001,
		ST_DIV_SAT = 9'b000000010,
		ST_DIV_HUE = 9'b000000100,
		ST_MAC     = 9'b000001000,
		ST_WGT     = 9'b000010000,
		ST_SUM     = 9'b000100000,
		ST_FIN     = 9'b001000000,
		ST_RD_LOAD = 9'b010000000,
		ST_RD_DIV  = 9'b100000000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [ppdn_pkg::CFG_W-1:0] coef_a_q [2];
	logic [ppdn_pkg::CFG_W-1:0] coef_b_q [2];
	logic [1:0]                 dims_q;
	logic [7:0]                 thresh_q;

	// Frame state.
	logic [CW-1:0] wr_cnt_q;
	logic [CW-1:0] rd_cnt_q;
	logic [31:0]   min_q;
	logic [31:0]   max_q;
	logic          closed_q;

	// Frame memory: bit 32 is the brightness flag, bits 31:0 the distance.
	logic [32:0] mem [FRAME_PIXELS];
	logic [32:0] rd_data_q;
	logic        mem_re;

	// Per-pixel working registers.
	logic [7:0]  blu_q, grn_q, red_q, val_q, diff_q;
	logic [7:0]  hmag_q;
	logic        hneg_q;
	logic [15:0] hbase_q;
	logic        bright_q;
	logic        last_q;
	logic [15:0] sat_q;
	logic [15:0] hue_q;

	// Shared divider.
	logic [DIV_W-1:0] rem_q, dsh_q;
	logic [15:0]      quo_q;
	logic [3:0]       step_q;

	// Projection datapath.
	logic                     dim_q;
	logic [2:0]               term_q;
	logic signed [32:0]       prod_q;
	ppdn_pkg::prod_shift_t    psh_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic [MAG_W+15:0]        wprod_q;
	logic [SUM_W-1:0]         sum_q;

	logic              done_q;
	ppdn_pkg::result_t result_q;

	logic accept;
	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

	// Input-side HSV preparation.
	logic [7:0]  in_max, in_min, in_diff;
	logic [7:0]  in_hmag;
	logic        in_hneg;
	logic [15:0] in_hbase;

	always_comb begin
		in_max = (cmd.blue > cmd.green) ? cmd.blue : cmd.green;
		in_min = (cmd.blue < cmd.green) ? cmd.blue : cmd.green;
		if (cmd.red > in_max) in_max = cmd.red;
		if (cmd.red < in_min) in_min = cmd.red;
		in_diff = in_max - in_min;
		priority if (in_max == cmd.red) begin
			in_hbase = 16'd0;
			in_hneg  = cmd.green < cmd.blue;
			in_hmag  = in_hneg ? cmd.blue - cmd.green : cmd.green - cmd.blue;
		end else if (in_max == cmd.green) begin
			in_hbase = ppdn_pkg::HUE_BASE_G;
			in_hneg  = cmd.blue < cmd.red;
			in_hmag  = in_hneg ? cmd.red - cmd.blue : cmd.blue - cmd.red;
		end else begin
			in_hbase = ppdn_pkg::HUE_BASE_B;
			in_hneg  = cmd.red < cmd.green;
			in_hmag  = in_hneg ? cmd.green - cmd.red : cmd.red - cmd.green;
		end
	end

	// One shift-subtract step per cycle; the quotient is known to fit 16 bits.
	logic             div_ge;
	logic [DIV_W-1:0] rem_nxt;
	logic [15:0]      quo_nxt;
	logic             div_last;

	assign div_ge   = (rem_q >= dsh_q);
	assign rem_nxt  = div_ge ? rem_q - dsh_q : rem_q;
	assign quo_nxt  = {quo_q[14:0], div_ge};
	assign div_last = (step_q == 4'd15);

	// Saturation division operands: (diff * 32768 + v/2) / v.
	logic [DIV_W-1:0] sat_num;
	logic [32:0]      sat_den;
	assign sat_num = DIV_W'({in_diff, 15'd0}) + DIV_W'(in_max >> 1);
	assign sat_den = 33'(in_max);

	// Hue division operands: (15360 * |num| + diff) / (2 * diff).
	logic [DIV_W-1:0] hue_num;
	logic [32:0]      hue_den;
	assign hue_num = DIV_W'(hmag_q * 24'(ppdn_pkg::HUE_STEP2)) + DIV_W'(diff_q);
	assign hue_den = 33'({diff_q, 1'b0});

	// Hue from the rounded quotient, wrapped into [0, 360) degrees.
	logic [16:0] hue_sum;
	logic [15:0] hue_val;
	always_comb begin
		if (!hneg_q) begin
			hue_sum = 17'(hbase_q) + 17'(quo_nxt);
		end else if (hbase_q >= quo_nxt) begin
			hue_sum = 17'(hbase_q) - 17'(quo_nxt);
		end else begin
			hue_sum = 17'(hbase_q) + ppdn_pkg::HUE_WRAP - 17'(quo_nxt);
		end
		hue_val = (diff_q == 8'd0) ? 16'd0 : hue_sum[15:0];
	end

	// Coefficient words of the current dimension.
	logic [ppdn_pkg::CFG_W-1:0] cw_a, cw_b;
	assign cw_a = coef_a_q[dim_q];
	assign cw_b = coef_b_q[dim_q];

	// Term selection for the shared multiplier.
	logic signed [15:0]    mul_coef;
	logic [15:0]           mul_feat;
	ppdn_pkg::prod_shift_t mul_sh;
	always_comb begin
		unique case (term_q)
			3'd0: begin
				mul_coef = cw_a[15:0];  mul_feat = 16'(blu_q); mul_sh = ppdn_pkg::SH_15;
			end
			3'd1: begin
				mul_coef = cw_a[31:16]; mul_feat = 16'(grn_q); mul_sh = ppdn_pkg::SH_15;
			end
			3'd2: begin
				mul_coef = cw_a[47:32]; mul_feat = 16'(red_q); mul_sh = ppdn_pkg::SH_15;
			end
			3'd3: begin
				mul_coef = cw_a[63:48]; mul_feat = hue_q;      mul_sh = ppdn_pkg::SH_8;
			end
			3'd4: begin
				mul_coef = cw_b[15:0];  mul_feat = sat_q;      mul_sh = ppdn_pkg::SH_0;
			end
			3'd5: begin
				mul_coef = cw_b[31:16]; mul_feat = 16'(val_q); mul_sh = ppdn_pkg::SH_15;
			end
			default: begin
				mul_coef = 16'sd0;      mul_feat = 16'd0;      mul_sh = ppdn_pkg::SH_0;
			end
		endcase
	end

	logic signed [32:0] mul_res;
	assign mul_res = mul_coef * $signed({1'b0, mul_feat});

	logic signed [ACC_W-1:0] prod_ext, prod_shifted;
	always_comb begin
		prod_ext = {{(ACC_W-33){prod_q[32]}}, prod_q};
		unique case (psh_q)
			ppdn_pkg::SH_0:  prod_shifted = prod_ext;
			ppdn_pkg::SH_8:  prod_shifted = prod_ext <<< 8;
			ppdn_pkg::SH_15: prod_shifted = prod_ext <<< 15;
			default:         prod_shifted = prod_ext;
		endcase
	end

	// The accumulator starts at minus the center, taken from Q12.4 to Q.27.
	function automatic logic signed [ACC_W-1:0] acc_start(input logic [15:0] ctr);
		logic signed [ACC_W-1:0] ext;
		ext = {{(ACC_W-39){ctr[15]}}, ctr, 23'd0};
		return -ext;
	endfunction

	logic [ACC_W-1:0] acc_abs;
	assign acc_abs = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);

	// Rounded, saturated Q24.8 distance.
	logic [SUM_W:0] dist_rnd;
	logic [31:0]    dist_val;
	assign dist_rnd = {1'b0, sum_q} + (SUM_W+1)'(64'd1 << 26);
	assign dist_val = (|dist_rnd[SUM_W:59]) ? 32'hFFFF_FFFF : dist_rnd[58:27];

	// Rescale operands from the stored entry.
	logic [31:0]      rng;
	logic [31:0]      off;
	logic [DIV_W-1:0] lvl_num;
	assign rng     = max_q - min_q;
	assign off     = rd_data_q[31:0] - min_q;
	assign lvl_num = DIV_W'(off * 41'(ppdn_pkg::LEVEL_SCALE2)) + DIV_W'(rng);

	logic [7:0] lvl_val;
	assign lvl_val = (!rd_data_q[32] || rng == 32'd0) ? 8'd0 :
		(|quo_nxt[15:8]) ? ppdn_pkg::LEVEL_MAX : quo_nxt[7:0];

	logic [CW-1:0] rd_nxt;
	assign rd_nxt = rd_cnt_q + CW'(1);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_a_q[0] <= '0;
			coef_a_q[1] <= '0;
			coef_b_q[0] <= '0;
			coef_b_q[1] <= '0;
			dims_q      <= ppdn_pkg::DIMS_RST;
			thresh_q    <= ppdn_pkg::THRESH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ppdn_pkg::REG_DIM0_A: coef_a_q[0] <= cfg_data;
				ppdn_pkg::REG_DIM0_B: coef_b_q[0] <= cfg_data;
				ppdn_pkg::REG_DIM1_A: coef_a_q[1] <= cfg_data;
				ppdn_pkg::REG_DIM1_B: coef_b_q[1] <= cfg_data;
				ppdn_pkg::REG_DIMS:   dims_q      <= cfg_data[1:0];
				ppdn_pkg::REG_THRESH: thresh_q    <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Frame memory, one synchronous write and one synchronous read port. One item
	// is in flight at a time, so a read never overlaps a write of the same slot.
	logic mem_we;
	assign mem_we = (state_q == ST_FIN);
	assign mem_re = accept && cmd.op == ppdn_pkg::OP_READ && closed_q && rd_cnt_q < wr_cnt_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_cnt_q[AW-1:0]] <= {bright_q, dist_val};
		end
		if (mem_re) begin
			rd_data_q <= mem[rd_cnt_q[AW-1:0]];
		end
	end

	// Control and frame state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			wr_cnt_q <= '0;
			rd_cnt_q <= '0;
			min_q    <= '1;
			max_q    <= '0;
			closed_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (cmd.op == ppdn_pkg::OP_STORE) begin
							if (!closed_q) begin
								if (wr_cnt_q < CW'(FRAME_PIXELS)) begin
									state_q <= ST_DIV_SAT;
								end else if (cmd.last_pixel) begin
									closed_q <= 1'b1;
								end
							end
						end else if (closed_q) begin
							if (rd_cnt_q < wr_cnt_q) begin
								state_q <= ST_RD_LOAD;
							end else begin
								done_q   <= 1'b1;
								wr_cnt_q <= '0;
								rd_cnt_q <= '0;
								min_q    <= '1;
								max_q    <= '0;
								closed_q <= 1'b0;
							end
						end
					end
				end
				ST_DIV_SAT: if (div_last) state_q <= ST_DIV_HUE;
				ST_DIV_HUE: if (div_last) state_q <= ST_MAC;
				ST_MAC:     if (term_q == 3'd6) state_q <= ST_WGT;
				ST_WGT:     state_q <= ST_SUM;
				ST_SUM: begin
					state_q <= (!dim_q && dims_q[1]) ? ST_MAC : ST_FIN;
				end
				ST_FIN: begin
					state_q  <= ST_IDLE;
					wr_cnt_q <= wr_cnt_q + CW'(1);
					if (dist_val < min_q) min_q <= dist_val;
					if (dist_val > max_q) max_q <= dist_val;
					if (last_q) closed_q <= 1'b1;
				end
				ST_RD_LOAD: state_q <= ST_RD_DIV;
				ST_RD_DIV: begin
					if (div_last) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
						if (rd_nxt >= wr_cnt_q) begin
							wr_cnt_q <= '0;
							rd_cnt_q <= '0;
							min_q    <= '1;
							max_q    <= '0;
							closed_q <= 1'b0;
						end else begin
							rd_cnt_q <= rd_nxt;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				blu_q    <= cmd.blue;
				grn_q    <= cmd.green;
				red_q    <= cmd.red;
				val_q    <= in_max;
				diff_q   <= in_diff;
				hmag_q   <= in_hmag;
				hneg_q   <= in_hneg;
				hbase_q  <= in_hbase;
				bright_q <= in_max > thresh_q;
				last_q   <= cmd.last_pixel;
				sum_q    <= '0;
				rem_q    <= sat_num;
				dsh_q    <= {sat_den, 15'd0};
				quo_q    <= '0;
				step_q   <= '0;
			end
			ST_DIV_SAT: begin
				rem_q  <= rem_nxt;
				dsh_q  <= dsh_q >> 1;
				quo_q  <= quo_nxt;
				step_q <= step_q + 4'd1;
				if (div_last) begin
					sat_q  <= (val_q == 8'd0) ? 16'd0 : quo_nxt;
					rem_q  <= hue_num;
					dsh_q  <= {hue_den, 15'd0};
					quo_q  <= '0;
					step_q <= '0;
				end
			end
			ST_DIV_HUE: begin
				rem_q  <= rem_nxt;
				dsh_q  <= dsh_q >> 1;
				quo_q  <= quo_nxt;
				step_q <= step_q + 4'd1;
				if (div_last) begin
					hue_q  <= hue_val;
					dim_q  <= 1'b0;
					term_q <= '0;
					acc_q  <= acc_start(coef_b_q[0][47:32]);
				end
			end
			ST_MAC: begin
				// Issue one product per cycle, add the previous one.
				prod_q <= mul_res;
				psh_q  <= mul_sh;
				term_q <= term_q + 3'd1;
				if (term_q != 3'd0) acc_q <= acc_q + prod_shifted;
			end
			ST_WGT: begin
				wprod_q <= acc_abs[MAG_W-1:0] * cw_b[63:48];
			end
			ST_SUM: begin
				sum_q  <= sum_q + SUM_W'(wprod_q);
				dim_q  <= 1'b1;
				term_q <= '0;
				acc_q  <= acc_start(coef_b_q[1][47:32]);
			end
			ST_FIN: ;
			ST_RD_LOAD: begin
				rem_q  <= lvl_num;
				dsh_q  <= {rng, 16'd0};
				quo_q  <= '0;
				step_q <= '0;
			end
			ST_RD_DIV: begin
				rem_q  <= rem_nxt;
				dsh_q  <= dsh_q >> 1;
				quo_q  <= quo_nxt;
				step_q <= step_q + 4'd1;
				if (div_last) begin
					result_q.level        <= lvl_val;
					result_q.end_of_frame <= (rd_nxt >= wr_cnt_q);
				end
			end
			default: ;
		endcase
		if (state_q == ST_IDLE && accept && cmd.op == ppdn_pkg::OP_READ) begin
			result_q.level        <= 8'd0;
			result_q.end_of_frame <= 1'b1;
		end
	end

	`PPDN_ASSERT(a_done_idle, clk, arst_n, done |-> !busy, "result strobe while busy")
	`PPDN_ASSERT(a_wr_bound, clk, arst_n, wr_cnt_q <= CW'(FRAME_PIXELS), "write count past frame")
	`PPDN_ASSERT(a_rd_bound, clk, arst_n, rd_cnt_q <= wr_cnt_q, "read count passed write count")
	`PPDN_ASSERT(a_minmax, clk, arst_n, wr_cnt_q == '0 || min_q <= max_q, "frame min above max")
	`PPDN_ASSERT_NEXT(a_busy_src, clk, arst_n, !busy && !start, !busy, "busy without a command")

endmodule

`default_nettype wire

>>> test/tb_top.sv
// Regression bench for pixel_pca_distance_normalizer_unit: it drives pixel frames and
// register settings and checks every level result against an in-bench predictor.
// Depends on ppdn_pkg and the RTL top level.
`timescale 1ns / 1ps

module tb_top;

	localparam int FRAMES       = ppdn_pkg::FRAME_PIXELS_DEF;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int ITEM_COUNT   = 1200;
	// Drain time before a register write: a store has no result, and the
	// longest store is one with two dimensions.
	localparam int STORE_DRAIN  = 64;
	localparam logic [ppdn_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [ppdn_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	logic                           clk;
	logic                           arst_n;
	logic                           start;
	logic                           busy;
	ppdn_pkg::cmd_t                 cmd;
	logic                           done;
	ppdn_pkg::result_t              result;
	logic                           cfg_we;
	logic [ppdn_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [ppdn_pkg::CFG_W-1:0]     cfg_data;

	pixel_pca_distance_normalizer_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Predictor copy of the registers.
	logic [63:0] coef_a [2];
	logic [63:0] coef_b [2];
	logic [1:0]  dims_reg;
	logic [7:0]  thresh_reg;

	// Predictor copy of the frame.
	logic [31:0] frame_dist [FRAMES];
	bit          frame_bright [FRAMES];
	logic [31:0] dist_min;
	logic [31:0] dist_max;
	int          stored_cnt;
	int          read_cnt;
	bit          frame_closed;

	ppdn_pkg::result_t pending_levels [$];
	int                error_cnt;
	int                cycle_cnt;
	int                sent_cnt;
	bit                steady;     // when set, the command side never idles

	always #5 clk = ~clk;

	// Signed 16-bit field of a 64-bit register word.
	function automatic longint coef_field(logic [63:0] word, int idx);
		logic signed [15:0] h;
		h = word[16*idx +: 16];
		return longint'(h);
	endfunction

	// Weighted absolute distance of one projection dimension, Q.35, modulo 2^64.
	function automatic longint unsigned dim_term(int d, longint b, longint g, longint r,
			longint h, longint s, longint v);
		longint          acc;
		longint unsigned mag;
		acc = (coef_field(coef_a[d], 0) * b + coef_field(coef_a[d], 1) * g +
			coef_field(coef_a[d], 2) * r + coef_field(coef_b[d], 1) * v) * 32768;
		acc += coef_field(coef_a[d], 3) * h * 256;
		acc += coef_field(coef_b[d], 0) * s;
		acc -= coef_field(coef_b[d], 2) * 8388608;
		mag = (acc < 0) ? longint'(-acc) : longint'(acc);
		return mag * longint'(coef_b[d][63:48]);
	endfunction

	function automatic void frame_clear();
		dist_min     = '1;
		dist_max     = '0;
		stored_cnt   = 0;
		read_cnt     = 0;
		frame_closed = 0;
	endfunction

	// Hue, saturation and value as the block forms them, then the distance.
	function automatic void store_pixel(longint b, longint g, longint r);
		longint          v, mn, diff, h, s, num, base, mag, q;
		longint unsigned sum, dist_full;
		int              n;
		v = (b > g) ? b : g;
		mn = (b < g) ? b : g;
		if (r > v) v = r;
		if (r < mn) mn = r;
		diff = v - mn;
		h = 0;
		s = 0;
		if (v != 0) s = (diff * 32768 + v / 2) / v;
		if (diff != 0) begin
			if (v == r) begin
				num = g - b; base = 0;
			end else if (v == g) begin
				num = b - r; base = 15360;
			end else begin
				num = r - g; base = 30720;
			end
			// Rounding is half away from zero on the magnitude.
			mag = (num < 0) ? -7680 * num : 7680 * num;
			q = (mag * 2 + diff) / (2 * diff);
			h = base + ((num < 0) ? -q : q);
			if (h < 0) h += 46080;
		end
		n = (dims_reg == 0) ? 1 : (dims_reg == 3) ? 2 : int'(dims_reg);
		sum = 0;
		for (int k = 0; k < n; k++) sum += dim_term(k, b, g, r, h, s, v);
		dist_full = (sum + (64'd1 << 26)) >> 27;
		if (dist_full > 64'hFFFF_FFFF) dist_full = 64'hFFFF_FFFF;
		frame_dist[stored_cnt]   = dist_full[31:0];
		frame_bright[stored_cnt] = (v > longint'(thresh_reg));
		if (dist_full[31:0] < dist_min) dist_min = dist_full[31:0];
		if (dist_full[31:0] > dist_max) dist_max = dist_full[31:0];
		stored_cnt++;
	endfunction

	// Advance the predictor by one accepted command and queue any level it owes.
	function automatic void predict_cmd(ppdn_pkg::cmd_t c);
		ppdn_pkg::result_t res;
		longint unsigned   span, off, lvl;
		if (c.op == ppdn_pkg::OP_STORE) begin
			if (frame_closed) return;
			if (stored_cnt < FRAMES) store_pixel(c.blue, c.green, c.red);
			if (c.last_pixel) frame_closed = 1;
			return;
		end
		if (!frame_closed) return;
		if (read_cnt >= stored_cnt) begin
			res.level = '0;
			res.end_of_frame = 1'b1;
			frame_clear();
		end else begin
			lvl = 0;
			if (frame_bright[read_cnt] && dist_max > dist_min) begin
				span = dist_max - dist_min;
				off  = frame_dist[read_cnt] - dist_min;
				lvl  = (off * 510 + span) / (2 * span);
				if (lvl > 255) lvl = 255;
			end
			res.level = lvl[7:0];
			read_cnt++;
			res.end_of_frame = (read_cnt >= stored_cnt);
			if (res.end_of_frame) frame_clear();
		end
		pending_levels = {pending_levels, res};
	endfunction

	// Every level transfer is checked against the oldest expectation.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (arst_n && done) begin
			if (pending_levels.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual level %0d eof %0b",
					$time, result.level, result.end_of_frame);
				error_cnt++;
			end else begin
				if (result.level !== pending_levels[0].level) begin
					$display("%0t: level mismatch, expected %0d, actual %0d",
						$time, pending_levels[0].level, result.level);
					error_cnt++;
				end
				if (result.end_of_frame !== pending_levels[0].end_of_frame) begin
					$display("%0t: end_of_frame mismatch, expected %0b, actual %0b",
						$time, pending_levels[0].end_of_frame, result.end_of_frame);
					error_cnt++;
				end
				void'(pending_levels.pop_front());
			end
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("pixel_pca_distance_normalizer_unit regression: fail");
			$finish;
		end
	end

	// One command transfer. Inputs change on the falling edge; busy only moves at a
	// rising edge, so busy low at a falling edge means the next rising edge accepts.
	task automatic send_cmd(ppdn_pkg::cmd_t c);
		@(negedge clk);
		while (!steady && $urandom_range(99) < 37) begin
			start = 1'b0;
			@(negedge clk);
		end
		start = 1'b1;
		cmd   = c;
		while (busy) @(negedge clk);
		@(posedge clk);
		predict_cmd(c);
		sent_cnt++;
	endtask

	task automatic send_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r, logic last);
		ppdn_pkg::cmd_t c;
		c = '{op: ppdn_pkg::OP_STORE, blue: b, green: g, red: r, last_pixel: last};
		send_cmd(c);
	endtask

	// A read carries random bytes in the unused fields.
	task automatic send_read();
		ppdn_pkg::cmd_t c;
		c.op         = ppdn_pkg::OP_READ;
		c.blue       = 8'($urandom);
		c.green      = 8'($urandom);
		c.red        = 8'($urandom);
		c.last_pixel = 1'($urandom);
		send_cmd(c);
	endtask

	// Wait until all levels are back and any store in flight has finished.
	task automatic drain();
		@(negedge clk);
		start = 1'b0;
		while (pending_levels.size() != 0) @(posedge clk);
		@(posedge clk);
		while (busy) @(posedge clk);
		repeat (STORE_DRAIN) @(posedge clk);
	endtask

	task automatic write_reg(logic [ppdn_pkg::CFG_IDX_W-1:0] idx,
			logic [ppdn_pkg::CFG_W-1:0] data);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			ppdn_pkg::REG_DIM0_A: coef_a[0] = data;
			ppdn_pkg::REG_DIM0_B: coef_b[0] = data;
			ppdn_pkg::REG_DIM1_A: coef_a[1] = data;
			ppdn_pkg::REG_DIM1_B: coef_b[1] = data;
			ppdn_pkg::REG_DIMS:   dims_reg = data[1:0];
			ppdn_pkg::REG_THRESH: thresh_reg = data[7:0];
			default: ;
		endcase
	endtask

	// Reads until the predictor says the frame has been handed back.
	task automatic read_frame();
		while (frame_closed) send_read();
	endtask

	task automatic random_config();
		logic [63:0] w;
		drain();
		for (int d = 0; d < 2; d++) begin
			w = {$urandom, $urandom};
			write_reg(d ? ppdn_pkg::REG_DIM1_A : ppdn_pkg::REG_DIM0_A, w);
			// Keep the weight modest most of the time so levels spread.
			w = {$urandom, $urandom};
			if ($urandom_range(3) != 0) w[63:48] = 16'($urandom_range(1024));
			write_reg(d ? ppdn_pkg::REG_DIM1_B : ppdn_pkg::REG_DIM0_B, w);
		end
		write_reg(ppdn_pkg::REG_DIMS, {$urandom, $urandom});
		write_reg(ppdn_pkg::REG_THRESH,
			{32'd0, ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(60)});
	endtask

	// Reset values: all coefficients zero, so every level is zero. A read
	// before the frame closes must give nothing.
	task automatic test_reset_values();
		send_read();
		send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
		send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
		send_pixel(8'd45, 8'd46, 8'd10, 1'b1);
		send_pixel(8'd9, 8'd9, 8'd9, 1'b0);   // dropped, frame is closed
		read_frame();
	endtask

	// Corners of the hue and saturation arithmetic under a working setting.
	task automatic test_hsv_corners();
		logic [23:0] pix [20];
		drain();
		write_reg(ppdn_pkg::REG_DIM0_A, 64'h0400_F000_1000_0010);
		write_reg(ppdn_pkg::REG_DIM0_B, 64'h0100_0200_FF00_0800);
		write_reg(ppdn_pkg::REG_THRESH, 64'd45);
		pix = '{24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF,
			24'h1020FF, 24'h2010FF, 24'h10FF20, 24'h20FF10, 24'hFF1020,
			24'hFF2010, 24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'h2D2D00,
			24'h2E0000, 24'h01FE80, 24'h808081, 24'h7F8080, 24'hAA55FF};
		for (int i = 0; i < 20; i++)
			send_pixel(pix[i][23:16], pix[i][15:8], pix[i][7:0], i == 19);
		read_frame();
	endtask

	// Extreme coefficients and weights push the distance into saturation;
	// dims 3 acts as two dimensions, and spare register indexes are ignored.
	task automatic test_extreme_registers();
		drain();
		write_reg(ppdn_pkg::REG_DIM0_A, 64'h7FFF_7FFF_7FFF_7FFF);
		write_reg(ppdn_pkg::REG_DIM0_B, 64'hFFFF_8000_7FFF_7FFF);
		write_reg(ppdn_pkg::REG_DIM1_A, 64'h8000_8000_8000_8000);
		write_reg(ppdn_pkg::REG_DIM1_B, 64'hFFFF_7FFF_8000_8000);
		write_reg(ppdn_pkg::REG_DIMS, 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(ppdn_pkg::REG_THRESH, 64'hFFFF_FFFF_FFFF_FF00);
		write_reg(REG_SPARE_LO, 64'h0);
		write_reg(REG_SPARE_HI, 64'h0123_4567_89AB_CDEF);
		send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
		send_pixel(8'd255, 8'd0, 8'd128, 1'b0);
		send_pixel(8'd1, 8'd254, 8'd3, 1'b1);
		read_frame();
		// Dims 0 acts as one dimension; threshold 255 masks every pixel.
		drain();
		write_reg(ppdn_pkg::REG_DIMS, 64'h4);
		write_reg(ppdn_pkg::REG_THRESH, 64'hFF);
		send_pixel(8'd255, 8'd200, 8'd7, 1'b0);
		send_pixel(8'd3, 8'd90, 8'd250, 1'b1);
		read_frame();
	endtask

	// Random frames with random content, occasional stray reads before the
	// frame closes, stray stores after it, and fresh register settings.
	task automatic test_random_frames();
		int n;
		while (sent_cnt < ITEM_COUNT) begin
			if ($urandom_range(5) == 0) random_config();
			// One long stretch in the middle of the run inserts no random idle cycles.
			steady = (sent_cnt >= 500 && sent_cnt < 800);
			n = ($urandom_range(9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 16);
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(12) == 0) send_read();
				send_pixel(8'($urandom), 8'($urandom), 8'($urandom), i == n - 1);
			end
			if ($urandom_range(5) == 0)
				send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
			read_frame();
		end
		steady = 0;
	endtask

	initial begin
		clk        = 1'b0;
		arst_n     = 1'b0;
		start      = 1'b0;
		cmd        = '0;
		cfg_we     = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		error_cnt  = 0;
		cycle_cnt  = 0;
		sent_cnt   = 0;
		steady     = 0;
		coef_a[0]  = '0;
		coef_a[1]  = '0;
		coef_b[0]  = '0;
		coef_b[1]  = '0;
		dims_reg   = ppdn_pkg::DIMS_RST;
		thresh_reg = ppdn_pkg::THRESH_RST;
		frame_clear();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_values();
		test_hsv_corners();
		test_extreme_registers();
		test_random_frames();
		drain();

		if (error_cnt == 0) begin
			$display("pixel_pca_distance_normalizer_unit regression: pass");
		end else begin
			$display("pixel_pca_distance_normalizer_unit regression: fail");
		end
		$finish;
	end

endmodule
